### design/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// rthsv_pkg
// Shared types, defaults and width helpers for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rthsv_pkg;

   localparam int COMPONENT_BITS_DEF = 8;
   localparam int HUE_FRAC_BITS_DEF  = 6;

   // Dominant component, picks the hue sector
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Side information carried down the divider chain next to the quotients
   typedef struct packed {
      logic       is_gray;
      logic       neg;
      sector_type sector;
   } hue_ctrl_type;

   // Quotient bits per division: saturation needs comp_bits, hue needs
   // enough for 60 degrees in fixed point.
   function automatic int quot_bits(input int comp_bits, input int frac_bits);
      return (comp_bits > frac_bits + 6) ? comp_bits : frac_bits + 6;
   endfunction

   // Bits for a hue below 360 degrees in fixed point
   function automatic int hue_bits(input int frac_bits);
      return $clog2(360 << frac_bits);
   endfunction

endpackage

### design/rthsv_ifs.sv
// ----------------------------------------------------------------------------
// rthsv_ifs
// Valid/ready channels for RGB pixels in and HSV pixels out.
// ----------------------------------------------------------------------------
interface rthsv_pixel_if #(
   parameter int COMPONENT_BITS = 8
);
   logic                      valid;
   logic                      ready;
   logic [COMPONENT_BITS-1:0] red;
   logic [COMPONENT_BITS-1:0] green;
   logic [COMPONENT_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_hsv_if #(
   parameter int COMPONENT_BITS = 8,
   parameter int HUE_BITS       = 15
);
   logic                      valid;
   logic                      ready;
   logic [HUE_BITS-1:0]       hue;
   logic [COMPONENT_BITS-1:0] saturation;
   logic [COMPONENT_BITS-1:0] brightness;
   logic                      is_gray;

   modport source (output valid, output hue, output saturation, output brightness,
                   output is_gray, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input is_gray, output ready);
endinterface

### design/rthsv_front.sv
// ----------------------------------------------------------------------------
// rthsv_front
// Input stage: max, min, sector and the two dividends for the divider chain.
// ----------------------------------------------------------------------------
module rthsv_front
   import rthsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   rthsv_pixel_if.sink                                             req_pix,
   output logic                                                    out_valid,
   input  logic                                                    out_ready,
   output logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] sat_word,
   output logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] hue_word,
   output logic [COMPONENT_BITS-1:0]                               max_val,
   output logic [COMPONENT_BITS-1:0]                               delta_val,
   output hue_ctrl_type                                            ctrl
);

   localparam int N  = COMPONENT_BITS;
   localparam int QB = quot_bits(COMPONENT_BITS, HUE_FRAC_BITS);
   localparam int DW = N + QB;
   localparam int SB = HUE_FRAC_BITS + 6;
   localparam logic [SB-1:0] SIXTY_FIX = SB'(60 << HUE_FRAC_BITS);

   logic              valid_ff, valid_in;
   logic [DW-1:0]     sat_word_ff, sat_word_in;
   logic [DW-1:0]     hue_word_ff, hue_word_in;
   logic [N-1:0]      max_ff, max_in;
   logic [N-1:0]      delta_ff, delta_in;
   hue_ctrl_type      ctrl_ff, ctrl_in;

   logic [N-1:0]      min_val, diff_a, diff_b, diff_mag;
   logic [N+SB-1:0]   hue_prod;
   logic [2*N-1:0]    sat_prod;
   logic              take;

   assign req_pix.ready = !valid_ff || out_ready;
   assign take          = req_pix.valid && req_pix.ready;

   always_comb begin
      ctrl_in = '0;
      if (req_pix.red >= req_pix.green && req_pix.red >= req_pix.blue) begin
         ctrl_in.sector = SECTOR_RED;
         max_in         = req_pix.red;
         diff_a         = req_pix.green;
         diff_b         = req_pix.blue;
      end else if (req_pix.green >= req_pix.blue) begin
         ctrl_in.sector = SECTOR_GREEN;
         max_in         = req_pix.green;
         diff_a         = req_pix.blue;
         diff_b         = req_pix.red;
      end else begin
         ctrl_in.sector = SECTOR_BLUE;
         max_in         = req_pix.blue;
         diff_a         = req_pix.red;
         diff_b         = req_pix.green;
      end
      min_val = req_pix.red;
      if (req_pix.green < min_val) min_val = req_pix.green;
      if (req_pix.blue < min_val)  min_val = req_pix.blue;
      delta_in        = max_in - min_val;
      ctrl_in.is_gray = (delta_in == '0);
      ctrl_in.neg     = diff_a < diff_b;
      diff_mag        = ctrl_in.neg ? diff_b - diff_a : diff_a - diff_b;
      // full scale times delta as a shift and subtract
      sat_prod        = {delta_in, {N{1'b0}}} - (2*N)'(delta_in);
      hue_prod        = diff_mag * SIXTY_FIX;
      sat_word_in     = DW'(sat_prod);
      hue_word_in     = DW'(hue_prod);
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_pix.ready) valid_in = req_pix.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sat_word_ff <= sat_word_in;
         hue_word_ff <= hue_word_in;
         max_ff      <= max_in;
         delta_ff    <= delta_in;
         ctrl_ff     <= ctrl_in;
      end
   end

   assign out_valid = valid_ff;
   assign sat_word  = sat_word_ff;
   assign hue_word  = hue_word_ff;
   assign max_val   = max_ff;
   assign delta_val = delta_ff;
   assign ctrl      = ctrl_ff;

endmodule

### design/rthsv_div_cell.sv
// ----------------------------------------------------------------------------
// rthsv_div_cell
// One restoring division step for both the saturation and hue quotients.
// ----------------------------------------------------------------------------
module rthsv_div_cell
   import rthsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    in_valid,
   output logic                                                    in_ready,
   input  logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] in_sat_word,
   input  logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] in_hue_word,
   input  logic [COMPONENT_BITS-1:0]                               in_max,
   input  logic [COMPONENT_BITS-1:0]                               in_delta,
   input  hue_ctrl_type                                            in_ctrl,
   output logic                                                    out_valid,
   input  logic                                                    out_ready,
   output logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] out_sat_word,
   output logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] out_hue_word,
   output logic [COMPONENT_BITS-1:0]                               out_max,
   output logic [COMPONENT_BITS-1:0]                               out_delta,
   output hue_ctrl_type                                            out_ctrl
);

   localparam int N  = COMPONENT_BITS;
   localparam int QB = quot_bits(COMPONENT_BITS, HUE_FRAC_BITS);
   localparam int DW = N + QB;

   // Word layout: partial remainder on top, unprocessed dividend bits below,
   // quotient bits shifting in at the bottom.
   logic          valid_ff, valid_in;
   logic [DW-1:0] sat_word_ff, sat_word_in;
   logic [DW-1:0] hue_word_ff, hue_word_in;
   logic [N-1:0]  max_ff;
   logic [N-1:0]  delta_ff;
   hue_ctrl_type  ctrl_ff;

   logic [N:0]    sat_trial, hue_trial;
   logic [N+1:0]  sat_sub, hue_sub;
   logic          sat_ge, hue_ge;
   logic          take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      sat_trial   = in_sat_word[DW-1:QB-1];
      sat_sub     = {1'b0, sat_trial} - {2'b00, in_max};
      sat_ge      = !sat_sub[N+1];
      sat_word_in = {(sat_ge ? sat_sub[N-1:0] : sat_trial[N-1:0]),
                     in_sat_word[QB-2:0], sat_ge};

      hue_trial   = in_hue_word[DW-1:QB-1];
      hue_sub     = {1'b0, hue_trial} - {2'b00, in_delta};
      hue_ge      = !hue_sub[N+1];
      hue_word_in = {(hue_ge ? hue_sub[N-1:0] : hue_trial[N-1:0]),
                     in_hue_word[QB-2:0], hue_ge};
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sat_word_ff <= sat_word_in;
         hue_word_ff <= hue_word_in;
         max_ff      <= in_max;
         delta_ff    <= in_delta;
         ctrl_ff     <= in_ctrl;
      end
   end

   assign out_valid    = valid_ff;
   assign out_sat_word = sat_word_ff;
   assign out_hue_word = hue_word_ff;
   assign out_max      = max_ff;
   assign out_delta    = delta_ff;
   assign out_ctrl     = ctrl_ff;

endmodule

### design/rthsv_back.sv
// ----------------------------------------------------------------------------
// rthsv_back
// Output stage: sector offset, hue wrap, grey override and result register.
// ----------------------------------------------------------------------------
module rthsv_back
   import rthsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    in_valid,
   output logic                                                    in_ready,
   input  logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] in_sat_word,
   input  logic [COMPONENT_BITS+quot_bits(COMPONENT_BITS,HUE_FRAC_BITS)-1:0] in_hue_word,
   input  logic [COMPONENT_BITS-1:0]                               in_max,
   input  hue_ctrl_type                                            in_ctrl,
   rthsv_hsv_if.source                                             rsp_hsv
);

   localparam int N   = COMPONENT_BITS;
   localparam int HB  = hue_bits(HUE_FRAC_BITS);
   localparam int HW  = HB + 1;
   localparam int SB  = HUE_FRAC_BITS + 6;
   localparam logic [HW-1:0] OFF_GREEN = HW'(120 << HUE_FRAC_BITS);
   localparam logic [HW-1:0] OFF_BLUE  = HW'(240 << HUE_FRAC_BITS);
   localparam logic [HW-1:0] FULL_TURN = HW'(360 << HUE_FRAC_BITS);

   logic          valid_ff, valid_in;
   logic [HB-1:0] hue_ff, hue_in;
   logic [N-1:0]  sat_ff, sat_in;
   logic [N-1:0]  bright_ff;
   logic          gray_ff;

   logic [HW-1:0] offset, quot, hue_full;
   logic          take;

   assign in_ready = !valid_ff || rsp_hsv.ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      case (in_ctrl.sector)
         SECTOR_RED:   offset = '0;
         SECTOR_GREEN: offset = OFF_GREEN;
         SECTOR_BLUE:  offset = OFF_BLUE;
         default:      offset = '0;
      endcase
      quot = HW'(in_hue_word[SB-1:0]);
      if (!in_ctrl.neg) begin
         hue_full = offset + quot;
      end else if (offset >= quot) begin
         hue_full = offset - quot;
      end else begin
         // below zero in the red sector: wrap by a full turn
         hue_full = offset + FULL_TURN - quot;
      end
      hue_in = in_ctrl.is_gray ? '0 : hue_full[HB-1:0];
      sat_in = in_ctrl.is_gray ? '0 : in_sat_word[N-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_max;
         gray_ff   <= in_ctrl.is_gray;
      end
   end

   assign rsp_hsv.valid      = valid_ff;
   assign rsp_hsv.hue        = hue_ff;
   assign rsp_hsv.saturation = sat_ff;
   assign rsp_hsv.brightness = bright_ff;
   assign rsp_hsv.is_gray    = gray_ff;

   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && gray_ff) |-> (hue_ff == '0 && sat_ff == '0))
      else $error("grey result with non-zero hue or saturation");

   a_colour_sat: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !gray_ff) |-> (sat_ff != '0 && bright_ff != '0))
      else $error("coloured result with zero saturation or value");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (HW'(hue_ff) < FULL_TURN))
      else $error("hue at or above a full turn");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result valid straight after reset");

endmodule

### design/rgb_to_hsv_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// RGB to HSV pixel converter: input stage, chain of divider cells, output.
//
//   channel   direction  transfer
//   req_pix   in         one RGB pixel (red, green, blue)
//   rsp_hsv   out        hue, saturation, brightness, is_gray
//
// One pixel per clock sustained while the result side is ready. Between the
// input stage and the output register sits the divider chain: one cell per quotient bit,
// QB = max(component bits, hue fraction bits + 6), both divisions side by side in each cell.
// Reset clears only the stage valid bits. Every stage holds while it is full and its
// successor cannot take, so a stalled result lets the empty stages keep filling.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
   import rthsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   rthsv_pixel_if.sink   req_pix,
   rthsv_hsv_if.source   rsp_hsv
);

   localparam int N  = COMPONENT_BITS;
   localparam int QB = quot_bits(COMPONENT_BITS, HUE_FRAC_BITS);
   localparam int DW = N + QB;

   logic          st_valid [QB+1];
   logic          st_ready [QB+1];
   logic [DW-1:0] st_sat   [QB+1];
   logic [DW-1:0] st_hue   [QB+1];
   logic [N-1:0]  st_max   [QB+1];
   logic [N-1:0]  st_delta [QB+1];
   hue_ctrl_type  st_ctrl  [QB+1];

   rthsv_front #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .HUE_FRAC_BITS  (HUE_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_pix   (req_pix),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .sat_word  (st_sat[0]),
      .hue_word  (st_hue[0]),
      .max_val   (st_max[0]),
      .delta_val (st_delta[0]),
      .ctrl      (st_ctrl[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_cell
      rthsv_div_cell #(
         .COMPONENT_BITS (COMPONENT_BITS),
         .HUE_FRAC_BITS  (HUE_FRAC_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (st_valid[k]),
         .in_ready     (st_ready[k]),
         .in_sat_word  (st_sat[k]),
         .in_hue_word  (st_hue[k]),
         .in_max       (st_max[k]),
         .in_delta     (st_delta[k]),
         .in_ctrl      (st_ctrl[k]),
         .out_valid    (st_valid[k+1]),
         .out_ready    (st_ready[k+1]),
         .out_sat_word (st_sat[k+1]),
         .out_hue_word (st_hue[k+1]),
         .out_max      (st_max[k+1]),
         .out_delta    (st_delta[k+1]),
         .out_ctrl     (st_ctrl[k+1])
      );
   end

   rthsv_back #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .HUE_FRAC_BITS  (HUE_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (st_valid[QB]),
      .in_ready    (st_ready[QB]),
      .in_sat_word (st_sat[QB]),
      .in_hue_word (st_hue[QB]),
      .in_max      (st_max[QB]),
      .in_ctrl     (st_ctrl[QB]),
      .rsp_hsv     (rsp_hsv)
   );

endmodule

### dv/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_checker
// Watches the pixel and HSV channels of the converter, works out the HSV
// value of every accepted pixel and compares it with the returned results
// in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_checker
   import rthsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF,
   parameter int HUE_BITS       = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pix_valid,
   input  logic                      pix_ready,
   input  logic [COMPONENT_BITS-1:0] pix_red,
   input  logic [COMPONENT_BITS-1:0] pix_green,
   input  logic [COMPONENT_BITS-1:0] pix_blue,
   input  logic                      hsv_valid,
   input  logic                      hsv_ready,
   input  logic [HUE_BITS-1:0]       hsv_hue,
   input  logic [COMPONENT_BITS-1:0] hsv_saturation,
   input  logic [COMPONENT_BITS-1:0] hsv_brightness,
   input  logic                      hsv_is_gray,
   output int                        fail_count,
   output int                        pending,
   output int                        n_done,
   output int                        n_gray,
   output int                        n_wrap
);

   localparam longint FULL_SCALE = (longint'(1) << COMPONENT_BITS) - 1;
   localparam longint SIXTY_DEG  = longint'(60) << HUE_FRAC_BITS;
   localparam longint FULL_TURN  = longint'(360) << HUE_FRAC_BITS;
   localparam int     EXP_DEPTH  = 64;

   typedef struct packed {
      logic [HUE_BITS-1:0]       hue;
      logic [COMPONENT_BITS-1:0] saturation;
      logic [COMPONENT_BITS-1:0] brightness;
      logic                      is_gray;
   } hsv_pixel_type;

   // expected results in arrival order, running write and read counts
   hsv_pixel_type exp_store [EXP_DEPTH];
   int            wr_idx    = 0;
   int            rd_idx    = 0;
   int            errors    = 0;
   int            done_cnt  = 0;
   int            gray_cnt  = 0;
   int            wrap_cnt  = 0;

   // Fixed-point RGB to HSV; wrapped flags a hue that went negative
   function automatic hsv_pixel_type rgb_to_hsv(input logic [COMPONENT_BITS-1:0] r,
                                                input logic [COMPONENT_BITS-1:0] g,
                                                input logic [COMPONENT_BITS-1:0] b,
                                                output logic wrapped);
      longint        rv, gv, bv, mx, mn, delta, hue;
      sector_type    sector;
      hsv_pixel_type px;
      rv = r;
      gv = g;
      bv = b;
      mx = (rv > gv) ? rv : gv;
      mx = (mx > bv) ? mx : bv;
      mn = (rv < gv) ? rv : gv;
      mn = (mn < bv) ? mn : bv;
      delta   = mx - mn;
      wrapped = 1'b0;
      px.brightness = mx[COMPONENT_BITS-1:0];
      if (delta == 0) begin
         px.hue        = '0;
         px.saturation = '0;
         px.is_gray    = 1'b1;
         return px;
      end
      px.is_gray    = 1'b0;
      px.saturation = COMPONENT_BITS'((FULL_SCALE * delta) / mx);
      // ties go to red first, then green
      if (rv >= mx) begin
         sector = SECTOR_RED;
      end else if (gv >= mx) begin
         sector = SECTOR_GREEN;
      end else begin
         sector = SECTOR_BLUE;
      end
      // signed division truncates toward zero
      case (sector)
         SECTOR_RED: begin
            hue = (SIXTY_DEG * (gv - bv)) / delta;
         end
         SECTOR_GREEN: begin
            hue = 2 * SIXTY_DEG + (SIXTY_DEG * (bv - rv)) / delta;
         end
         default: begin
            hue = 4 * SIXTY_DEG + (SIXTY_DEG * (rv - gv)) / delta;
         end
      endcase
      if (hue < 0) begin
         hue     = hue + FULL_TURN;
         wrapped = 1'b1;
      end
      px.hue = hue[HUE_BITS-1:0];
      return px;
   endfunction

   always @(posedge clock) begin
      hsv_pixel_type exp_px;
      logic          wrapped;
      if (!reset) begin
         // a result at this edge belongs to a pixel taken at an earlier edge
         if (hsv_valid && hsv_ready) begin
            if (wr_idx == rd_idx) begin
               $display("%0t: unexpected HSV transfer hue=%0d sat=%0d val=%0d grey=%0b",
                        $time, hsv_hue, hsv_saturation, hsv_brightness, hsv_is_gray);
               errors++;
            end else begin
               exp_px = exp_store[rd_idx % EXP_DEPTH];
               rd_idx++;
               done_cnt++;
               if (hsv_hue !== exp_px.hue) begin
                  $display("%0t: hue mismatch, expected %0d, got %0d",
                           $time, exp_px.hue, hsv_hue);
                  errors++;
               end
               if (hsv_saturation !== exp_px.saturation) begin
                  $display("%0t: saturation mismatch, expected %0d, got %0d",
                           $time, exp_px.saturation, hsv_saturation);
                  errors++;
               end
               if (hsv_brightness !== exp_px.brightness) begin
                  $display("%0t: brightness mismatch, expected %0d, got %0d",
                           $time, exp_px.brightness, hsv_brightness);
                  errors++;
               end
               if (hsv_is_gray !== exp_px.is_gray) begin
                  $display("%0t: is_gray mismatch, expected %0b, got %0b",
                           $time, exp_px.is_gray, hsv_is_gray);
                  errors++;
               end
            end
         end
         if (pix_valid && pix_ready) begin
            exp_px = rgb_to_hsv(pix_red, pix_green, pix_blue, wrapped);
            if (wr_idx - rd_idx >= EXP_DEPTH) begin
               $display("%0t: more than %0d pixels outstanding, expected %0d, got %0d",
                        $time, EXP_DEPTH, EXP_DEPTH, wr_idx - rd_idx + 1);
               errors++;
            end else begin
               exp_store[wr_idx % EXP_DEPTH] = exp_px;
               wr_idx++;
            end
            if (exp_px.is_gray) gray_cnt++;
            if (wrapped) wrap_cnt++;
         end
      end
      fail_count <= errors;
      pending    <= wr_idx - rd_idx;
      n_done     <= done_cnt;
      n_gray     <= gray_cnt;
      n_wrap     <= wrap_cnt;
   end

endmodule

### dv/tb_rgb_to_hsv_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_top
// Drives directed and random RGB pixels into the converter with random
// gaps and output back-pressure; the checker predicts and compares every
// HSV result and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_top;
   import rthsv_pkg::*;

   localparam int CB          = COMPONENT_BITS_DEF;
   localparam int HF          = HUE_FRAC_BITS_DEF;
   localparam int HUE_BITS    = hue_bits(HF);
   localparam int N_RANDOM    = 1500;
   localparam int CALM_TAIL   = 300;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_DIRECTED  = 21;

   localparam logic [23:0] DIRECTED_PIX [N_DIRECTED] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,  // grey, black, white
      24'hFF0000, 24'h00FF00, 24'h0000FF,              // primaries
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF,              // ties for the max
      24'hFF0001, 24'h01FF00, 24'h0100FF,              // near sector edges
      24'hFEFFFF, 24'hFFFEFE, 24'h010000, 24'h000001,  // smallest deltas
      24'h80FF7F, 24'h7F0080, 24'h55AA00, 24'hAA0055
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on = 1'b1;
   int   cycle_count = 0;
   int   stall_left = 0;
   int   fail_count, pending, n_done, n_gray, n_wrap;

   rthsv_pixel_if #(.COMPONENT_BITS(CB)) req_pix ();
   rthsv_hsv_if #(.COMPONENT_BITS(CB), .HUE_BITS(HUE_BITS)) rsp_hsv ();

   rgb_to_hsv_pixel_top #(
      .COMPONENT_BITS (CB),
      .HUE_FRAC_BITS  (HF)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_pix (req_pix),
      .rsp_hsv (rsp_hsv)
   );

   rgb_to_hsv_pixel_checker #(
      .COMPONENT_BITS (CB),
      .HUE_FRAC_BITS  (HF),
      .HUE_BITS       (HUE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .pix_valid      (req_pix.valid),
      .pix_ready      (req_pix.ready),
      .pix_red        (req_pix.red),
      .pix_green      (req_pix.green),
      .pix_blue       (req_pix.blue),
      .hsv_valid      (rsp_hsv.valid),
      .hsv_ready      (rsp_hsv.ready),
      .hsv_hue        (rsp_hsv.hue),
      .hsv_saturation (rsp_hsv.saturation),
      .hsv_brightness (rsp_hsv.brightness),
      .hsv_is_gray    (rsp_hsv.is_gray),
      .fail_count     (fail_count),
      .pending        (pending),
      .n_done         (n_done),
      .n_gray         (n_gray),
      .n_wrap         (n_wrap)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("rgb_to_hsv_pixel_top verification failed");
         $finish;
      end
   end

   // result side back-pressure in short bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_hsv.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_hsv.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left    <= $urandom_range(0, 2);
         rsp_hsv.ready <= 1'b0;
      end else begin
         rsp_hsv.ready <= 1'b1;
      end
   end

   // holds valid across back-to-back pixels; drops it only for a gap
   task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                             input logic [CB-1:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_pix.valid <= 1'b0;
         req_pix.red   <= CB'($urandom);
         req_pix.green <= CB'($urandom);
         req_pix.blue  <= CB'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_pix.valid <= 1'b1;
      req_pix.red   <= r;
      req_pix.green <= g;
      req_pix.blue  <= b;
      @(posedge clock);
      while (!req_pix.ready) @(posedge clock);
   endtask

   initial begin
      logic [CB-1:0] comp [3];
      int            hi, lo, pos;
      req_pix.valid <= 1'b0;
      req_pix.red   <= '0;
      req_pix.green <= '0;
      req_pix.blue  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PIX[i]) begin
         send_pixel(DIRECTED_PIX[i][23:16], DIRECTED_PIX[i][15:8], DIRECTED_PIX[i][7:0]);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         // alternate busy and calm stretches, calm to the end
         idle_on <= (i < N_RANDOM - CALM_TAIL) && ((i / 200) % 2 == 0);
         pos = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            4: begin
               comp[0] = CB'($urandom);
               comp[1] = comp[0];
               comp[2] = comp[0];
            end
            5: begin
               // two equal maxima, odd one below
               hi = $urandom_range(1, 255);
               lo = $urandom_range(0, hi - 1);
               comp = '{CB'(hi), CB'(hi), CB'(hi)};
               comp[pos] = CB'(lo);
            end
            6: begin
               // two equal minima, odd one above
               lo = $urandom_range(0, 254);
               hi = $urandom_range(lo + 1, 255);
               comp = '{CB'(lo), CB'(lo), CB'(lo)};
               comp[pos] = CB'(hi);
            end
            7: begin
               lo = $urandom_range(0, 253);
               foreach (comp[k]) comp[k] = CB'(lo + $urandom_range(0, 2));
            end
            8: begin
               foreach (comp[k]) comp[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               comp[pos] = CB'($urandom);
            end
            default: begin
               foreach (comp[k]) comp[k] = CB'($urandom);
            end
         endcase
         send_pixel(comp[0], comp[1], comp[2]);
      end
      req_pix.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("checked %0d HSV results: %0d grey pixels, %0d hues wrapped past zero",
               n_done, n_gray, n_wrap);
      $display("%0d directed pixels, %0d random, with and without gaps and stalls",
               N_DIRECTED, N_RANDOM);
      if (fail_count == 0 && pending == 0) begin
         $display("rgb_to_hsv_pixel_top verification clean");
      end else begin
         $display("rgb_to_hsv_pixel_top verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/rthsv_pkg.sv
design/rthsv_ifs.sv
design/rthsv_front.sv
design/rthsv_div_cell.sv
design/rthsv_back.sv
design/rgb_to_hsv_pixel_top.sv
dv/rgb_to_hsv_pixel_checker.sv
dv/tb_rgb_to_hsv_pixel_top.sv
